FILE: src/bdp_pkg.sv
// ----------------------------------------------------------------------------
// bdp_pkg
// shared widths, flag type and the arctangent table for the bearing/distance
// pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bdp_pkg;

  // internal word of the vectoring datapath, 2^64 = one full turn for angles
  localparam int WORD_W   = 64;
  localparam int HALF_W   = 32;
  // one rotation per stage, one root bit per stage
  localparam int ITERS    = 62;
  localparam int ROOT_W   = ITERS;
  localparam int RAD_W    = 2 * ITERS;
  localparam int REM_W    = 64;
  // threshold register and its square
  localparam int THR_W    = 20;
  localparam int THR_SQ_W = 2 * THR_W;
  // normalized magnitude lands in [2^(NORM_TOP-1), 2^NORM_TOP)
  localparam int NORM_TOP = 61;

  localparam logic [WORD_W-1:0] HALF_TURN    = 64'h8000_0000_0000_0000;
  localparam logic [WORD_W-1:0] EIGHTH_TURN  = 64'h2000_0000_0000_0000;
  localparam logic [WORD_W-1:0] TURN_PER_RAD = 64'd2935890503282001226;

  typedef struct packed {
    logic too_close;
    logic zero;
  } bdp_flags_t;

  // shift-subtract long division, elaboration only
  function automatic logic [WORD_W-1:0] bdp_div_floor(input logic [WORD_W-1:0] num,
                                                      input logic [WORD_W-1:0] den);
    logic [WORD_W-1:0] q;
    logic [WORD_W-1:0] r;
    q = '0;
    r = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      r = {r[WORD_W-2:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-idx) as a fraction of a turn, series in radians then scaled
  function automatic logic [WORD_W-1:0] bdp_atan_turn(input int unsigned idx);
    logic [WORD_W-1:0]   acc;
    logic [WORD_W-1:0]   term;
    logic [2*WORD_W-1:0] prod;
    int unsigned         e;
    int unsigned         den;
    acc = '0;
    if (idx == 0) begin
      return EIGHTH_TURN;
    end
    for (int unsigned k = 0; k < 32; k++) begin
      e   = idx * (2 * k + 1);
      den = 2 * k + 1;
      if (e <= 63) begin
        term = bdp_div_floor(WORD_W'(1) << (WORD_W - e), WORD_W'(den));
        if ((k & 1) != 0) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
    end
    prod = {{WORD_W{1'b0}}, acc} * {{WORD_W{1'b0}}, TURN_PER_RAD};
    return prod[2*WORD_W-1:WORD_W];
  endfunction

endpackage

`default_nettype wire

FILE: src/bdp_cordic.sv
// ----------------------------------------------------------------------------
// bdp_cordic
// unrolled vectoring rotator, one micro-rotation per register stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdp_cordic
  import bdp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [WORD_W-1:0] in_x,
  input  logic [WORD_W-1:0] in_y,
  input  logic [WORD_W-1:0] in_z,
  output logic              out_valid,
  output logic [WORD_W-1:0] out_z
);

  logic              valid_r [ITERS];
  logic [WORD_W-1:0] z_r     [ITERS];
  logic [WORD_W-1:0] x_r     [ITERS-2];
  logic [WORD_W-1:0] y_r     [ITERS-1];

  for (genvar i = 0; i < ITERS; i++) begin : g_stage
    localparam logic [WORD_W-1:0] ANG = bdp_atan_turn(i);

    logic              v_in;
    logic [WORD_W-1:0] y_in;
    logic [WORD_W-1:0] z_in;
    logic [WORD_W-1:0] z_nxt;

    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign y_in = in_y;
      assign z_in = in_z;
    end else begin : g_next
      assign v_in = valid_r[i-1];
      assign y_in = y_r[i-1];
      assign z_in = z_r[i-1];
    end

    // rotate toward the positive x axis
    assign z_nxt = y_in[WORD_W-1] ? (z_in - ANG) : (z_in + ANG);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else if (en) begin
        valid_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        z_r[i] <= z_nxt;
      end
    end

    // last stage only needs the angle, the one before it only the new y
    if (i < ITERS - 1) begin : g_y
      logic [WORD_W-1:0] x_in;
      logic [WORD_W-1:0] xs;
      logic [WORD_W-1:0] y_nxt;

      if (i == 0) begin : g_x_first
        assign x_in = in_x;
      end else begin : g_x_next
        assign x_in = x_r[i-1];
      end

      assign xs    = WORD_W'($signed(x_in) >>> i);
      assign y_nxt = y_in[WORD_W-1] ? (y_in + xs) : (y_in - xs);

      always_ff @(posedge clk) begin
        if (en) begin
          y_r[i] <= y_nxt;
        end
      end

      if (i < ITERS - 2) begin : g_x
        logic [WORD_W-1:0] ys;
        logic [WORD_W-1:0] x_nxt;

        assign ys    = WORD_W'($signed(y_in) >>> i);
        assign x_nxt = y_in[WORD_W-1] ? (x_in - ys) : (x_in + ys);

        always_ff @(posedge clk) begin
          if (en) begin
            x_r[i] <= x_nxt;
          end
        end
      end
    end
  end

  assign out_valid = valid_r[ITERS-1];
  assign out_z     = z_r[ITERS-1];

endmodule

`default_nettype wire

FILE: src/bdp_isqrt.sv
// ----------------------------------------------------------------------------
// bdp_isqrt
// pipelined digit-by-digit integer square root, one root bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdp_isqrt
  import bdp_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  in_rad,
  input  bdp_flags_t        in_flags,
  output logic [ROOT_W-1:0] out_root,
  output logic [REM_W-1:0]  out_rem,
  output bdp_flags_t        out_flags
);

  logic [ROOT_W-1:0] root_r  [ITERS];
  logic [REM_W-1:0]  rem_r   [ITERS];
  bdp_flags_t        flags_r [ITERS];
  logic [RAD_W-1:0]  rad_r   [ITERS-1];

  for (genvar k = 0; k < ITERS; k++) begin : g_stage
    logic [RAD_W-1:0]  rad_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W-1:0]  rem_in;
    bdp_flags_t        flags_in;
    logic [REM_W+1:0]  acc;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              take;

    if (k == 0) begin : g_first
      assign rad_in   = in_rad;
      assign root_in  = '0;
      assign rem_in   = '0;
      assign flags_in = in_flags;
    end else begin : g_next
      assign rad_in   = rad_r[k-1];
      assign root_in  = root_r[k-1];
      assign rem_in   = rem_r[k-1];
      assign flags_in = flags_r[k-1];
    end

    // bring down the next radicand pair and try 4r+1
    assign acc   = {rem_in, rad_in[RAD_W-1-2*k -: 2]};
    assign trial = (REM_W+2)'({root_in, 2'b01});
    assign diff  = acc - trial;
    assign take  = (acc >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k]  <= {root_in[ROOT_W-2:0], take};
        rem_r[k]   <= take ? REM_W'(diff) : REM_W'(acc);
        flags_r[k] <= flags_in;
      end
    end

    if (k < ITERS - 1) begin : g_rad
      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[k] <= rad_in;
        end
      end
    end
  end

  assign out_root  = root_r[ITERS-1];
  assign out_rem   = rem_r[ITERS-1];
  assign out_flags = flags_r[ITERS-1];

endmodule

`default_nettype wire

FILE: src/bearing_distance_polar.sv
// ----------------------------------------------------------------------------
// bearing_distance_polar: distance and bearing between two points
// throughput: one beat per cycle unless stalled
// 68 register stages, each holds one point pair
// stalls: a stalled result holds the pipeline only once its last stage is full
// reset: synchronous active-low rst_n clears valid bits, threshold returns to 1
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bearing_distance_polar
  import bdp_pkg::*;
#(
  parameter int COORD_WIDTH = 48,
  parameter int ANGLE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // point pair beats
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_from_east,
  input  logic signed [COORD_WIDTH-1:0] in_from_north,
  input  logic signed [COORD_WIDTH-1:0] in_to_east,
  input  logic signed [COORD_WIDTH-1:0] in_to_north,
  // result beats
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ANGLE_WIDTH-1:0]        out_bearing_angle,
  output logic [COORD_WIDTH:0]          out_distance,
  output logic                          out_too_close,
  // zero threshold register
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [THR_W-1:0]              cfg_zero_threshold
);

  // differences need one extra bit, |d| <= 2^COORD_WIDTH fits the same width
  localparam int MAG_W = COORD_WIDTH + 1;
  // half an output lsb, for round to nearest on the angle
  localparam logic [WORD_W-1:0] ROUND_ADD = WORD_W'(1) << (WORD_W - 1 - ANGLE_WIDTH);

  typedef struct packed {
    logic [WORD_W-1:0] m;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
  } norm_t;

  // one step of the leading-zero normalization: shift if the top sh bits are clear
  function automatic norm_t norm_step(input norm_t v, input int unsigned sh);
    norm_t r;
    r = v;
    if ((v.m >> (NORM_TOP - sh)) == '0) begin
      r.m = v.m << sh;
      r.x = v.x << sh;
      r.y = v.y << sh;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // threshold register, kept squared so the check needs no root
  // --------------------------------------------------------------------------
  logic [THR_SQ_W-1:0] thr_sq_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_sq_r <= THR_SQ_W'(1);
    end else if (cfg_valid) begin
      thr_sq_r <= THR_SQ_W'(cfg_zero_threshold) * THR_SQ_W'(cfg_zero_threshold);
    end
  end

  // --------------------------------------------------------------------------
  // flow control
  // the whole pipeline moves as one; it may also move while the output
  // register is stalled as long as the last stage holds a bubble, so a
  // waiting result blocks new beats only once a beat sits in the last stage
  // --------------------------------------------------------------------------
  logic out_valid_r;
  logic out_free;
  logic adv;
  logic core_valid;

  assign out_free = !out_valid_r || !out_stall;
  assign adv      = out_free || !core_valid;
  assign in_stall = !adv;

  // --------------------------------------------------------------------------
  // s0: coordinate differences, dx north, dy east
  // --------------------------------------------------------------------------
  logic             s0_valid_r;
  logic [MAG_W-1:0] s0_dx_r;
  logic [MAG_W-1:0] s0_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_dx_r <= {in_to_north[COORD_WIDTH-1], in_to_north}
               - {in_from_north[COORD_WIDTH-1], in_from_north};
      s0_dy_r <= {in_to_east[COORD_WIDTH-1], in_to_east}
               - {in_from_east[COORD_WIDTH-1], in_from_east};
    end
  end

  // --------------------------------------------------------------------------
  // s1: magnitudes for the squares, sign-extended vector for the rotator
  // --------------------------------------------------------------------------
  logic              s1_valid_r;
  logic [MAG_W-1:0]  s1_ax_r;
  logic [MAG_W-1:0]  s1_ay_r;
  logic [WORD_W-1:0] s1_x_r;
  logic [WORD_W-1:0] s1_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ax_r <= s0_dx_r[MAG_W-1] ? (~s0_dx_r + 1'b1) : s0_dx_r;
      s1_ay_r <= s0_dy_r[MAG_W-1] ? (~s0_dy_r + 1'b1) : s0_dy_r;
      s1_x_r  <= {{(WORD_W-MAG_W){s0_dx_r[MAG_W-1]}}, s0_dx_r};
      s1_y_r  <= {{(WORD_W-MAG_W){s0_dy_r[MAG_W-1]}}, s0_dy_r};
    end
  end

  // --------------------------------------------------------------------------
  // s2: 32x32 partial products of both squares, first half of normalization
  // --------------------------------------------------------------------------
  logic [WORD_W-1:0] ax_w;
  logic [WORD_W-1:0] ay_w;
  norm_t             norm_a0;
  norm_t             norm_a;

  logic              s2_valid_r;
  logic [WORD_W-1:0] s2_pxll_r;
  logic [WORD_W-1:0] s2_pxlh_r;
  logic [WORD_W-1:0] s2_pxhh_r;
  logic [WORD_W-1:0] s2_pyll_r;
  logic [WORD_W-1:0] s2_pylh_r;
  logic [WORD_W-1:0] s2_pyhh_r;
  norm_t             s2_norm_r;

  assign ax_w = WORD_W'(s1_ax_r);
  assign ay_w = WORD_W'(s1_ay_r);

  always_comb begin
    norm_a0.m = ax_w | ay_w;
    norm_a0.x = s1_x_r;
    norm_a0.y = s1_y_r;
    norm_a    = norm_step(norm_step(norm_step(norm_a0, 32), 16), 8);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_pxll_r <= WORD_W'(ax_w[HALF_W-1:0]) * WORD_W'(ax_w[HALF_W-1:0]);
      s2_pxlh_r <= WORD_W'(ax_w[HALF_W-1:0]) * WORD_W'(ax_w[WORD_W-1:HALF_W]);
      s2_pxhh_r <= WORD_W'(ax_w[WORD_W-1:HALF_W]) * WORD_W'(ax_w[WORD_W-1:HALF_W]);
      s2_pyll_r <= WORD_W'(ay_w[HALF_W-1:0]) * WORD_W'(ay_w[HALF_W-1:0]);
      s2_pylh_r <= WORD_W'(ay_w[HALF_W-1:0]) * WORD_W'(ay_w[WORD_W-1:HALF_W]);
      s2_pyhh_r <= WORD_W'(ay_w[WORD_W-1:HALF_W]) * WORD_W'(ay_w[WORD_W-1:HALF_W]);
      s2_norm_r <= norm_a;
    end
  end

  // --------------------------------------------------------------------------
  // s3: assemble the squares, finish normalization, spot the null vector
  // --------------------------------------------------------------------------
  logic [2*WORD_W-1:0] sqx_full;
  logic [2*WORD_W-1:0] sqy_full;
  norm_t               norm_b;

  logic                s3_valid_r;
  logic [RAD_W-1:0]    s3_sqx_r;
  logic [RAD_W-1:0]    s3_sqy_r;
  logic [WORD_W-1:0]   s3_x_r;
  logic [WORD_W-1:0]   s3_y_r;
  logic                s3_zero_r;

  // a^2 = hh*2^64 + 2*lh*2^32 + ll
  assign sqx_full = {s2_pxhh_r, {WORD_W{1'b0}}}
                  + ((2*WORD_W)'(s2_pxlh_r) << (HALF_W + 1))
                  + (2*WORD_W)'(s2_pxll_r);
  assign sqy_full = {s2_pyhh_r, {WORD_W{1'b0}}}
                  + ((2*WORD_W)'(s2_pylh_r) << (HALF_W + 1))
                  + (2*WORD_W)'(s2_pyll_r);

  assign norm_b = norm_step(norm_step(norm_step(s2_norm_r, 4), 2), 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_sqx_r  <= RAD_W'(sqx_full);
      s3_sqy_r  <= RAD_W'(sqy_full);
      s3_x_r    <= norm_b.x;
      s3_y_r    <= norm_b.y;
      s3_zero_r <= (norm_b.m == '0);
    end
  end

  // --------------------------------------------------------------------------
  // s4: sum of squares, fold the left half-plane onto the right
  // --------------------------------------------------------------------------
  logic              s4_valid_r;
  logic [RAD_W-1:0]  s4_rad_r;
  logic [WORD_W-1:0] s4_x_r;
  logic [WORD_W-1:0] s4_y_r;
  logic [WORD_W-1:0] s4_z_r;
  logic              s4_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_rad_r  <= s3_sqx_r + s3_sqy_r;
      s4_zero_r <= s3_zero_r;
      if (s3_x_r[WORD_W-1]) begin
        s4_x_r <= ~s3_x_r + 1'b1;
        s4_y_r <= ~s3_y_r + 1'b1;
        s4_z_r <= HALF_TURN;
      end else begin
        s4_x_r <= s3_x_r;
        s4_y_r <= s3_y_r;
        s4_z_r <= '0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // core: rotator and root run side by side, same depth, same enable
  // the threshold test on the exact sum of squares rides along as a flag
  // --------------------------------------------------------------------------
  bdp_flags_t        entry_flags;
  bdp_flags_t        core_flags;
  logic [WORD_W-1:0] core_z;
  logic [ROOT_W-1:0] core_root;
  logic [REM_W-1:0]  core_rem;

  always_comb begin
    entry_flags.too_close = (s4_rad_r[RAD_W-1:THR_SQ_W] == '0)
                          && (s4_rad_r[THR_SQ_W-1:0] < thr_sq_r);
    entry_flags.zero      = s4_zero_r;
  end

  bdp_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (s4_valid_r),
    .in_x      (s4_x_r),
    .in_y      (s4_y_r),
    .in_z      (s4_z_r),
    .out_valid (core_valid),
    .out_z     (core_z)
  );

  bdp_isqrt u_isqrt (
    .clk       (clk),
    .en        (adv),
    .in_rad    (s4_rad_r),
    .in_flags  (entry_flags),
    .out_root  (core_root),
    .out_rem   (core_rem),
    .out_flags (core_flags)
  );

  // --------------------------------------------------------------------------
  // output register: angle rounding, root rounding, forcing to zero
  // --------------------------------------------------------------------------
  logic [WORD_W-1:0]      bearing_sum;
  logic                   round_up;
  logic [ANGLE_WIDTH-1:0] bearing_nxt;
  logic [MAG_W-1:0]       distance_nxt;

  logic [ANGLE_WIDTH-1:0] out_bearing_angle_r;
  logic [MAG_W-1:0]       out_distance_r;
  logic                   out_too_close_r;

  // a full turn after rounding wraps to zero by dropping the carry
  assign bearing_sum = core_z + ROUND_ADD;
  // remainder above the root means the sum of squares is past r^2 + r
  assign round_up    = (core_rem > REM_W'(core_root));

  always_comb begin
    if (core_flags.too_close || core_flags.zero) begin
      bearing_nxt = '0;
    end else begin
      bearing_nxt = bearing_sum[WORD_W-1 -: ANGLE_WIDTH];
    end
    if (core_flags.too_close) begin
      distance_nxt = '0;
    end else begin
      distance_nxt = core_root[MAG_W-1:0] + MAG_W'(round_up);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= core_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_bearing_angle_r <= bearing_nxt;
      out_distance_r      <= distance_nxt;
      out_too_close_r     <= core_flags.too_close;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_bearing_angle = out_bearing_angle_r;
  assign out_distance      = out_distance_r;
  assign out_too_close     = out_too_close_r;

endmodule

`default_nettype wire

FILE: src/bdp_checker.sv
// ----------------------------------------------------------------------------
// bdp_checker
// port-level checks on the result and point pair channels, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdp_checker #(
  parameter int COORD_WIDTH = 48,
  parameter int ANGLE_WIDTH = 32
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [ANGLE_WIDTH-1:0] out_bearing_angle,
  input logic [COORD_WIDTH:0]   out_distance,
  input logic                   out_too_close
);

  // too close forces both results to zero
  a_close_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_too_close |-> out_bearing_angle == '0 && out_distance == '0)
    else $error("too_close beat with nonzero result");

  // a zero distance that is not too close can only come from a null vector
  a_null_bearing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_too_close && out_distance == '0 |-> out_bearing_angle == '0)
    else $error("null vector with nonzero bearing");

  // with the output register empty the pipeline always takes a beat
  a_accept_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output empty");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_distance)
      && $stable(out_bearing_angle) && $stable(out_too_close))
    else $error("stalled result beat changed");

endmodule

bind bearing_distance_polar bdp_checker #(
  .COORD_WIDTH (COORD_WIDTH),
  .ANGLE_WIDTH (ANGLE_WIDTH)
) u_bdp_checker (.*);

`default_nettype wire

FILE: dv/bearing_distance_checker.sv
// ----------------------------------------------------------------------------
// bearing_distance_checker
// watches the point pair, result and threshold channels, predicts bearing and
// distance for every accepted point pair and compares result beats in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bearing_distance_checker
  import bdp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic signed [47:0]   in_from_east,
  input  logic signed [47:0]   in_from_north,
  input  logic signed [47:0]   in_to_east,
  input  logic signed [47:0]   in_to_north,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [31:0]          out_bearing_angle,
  input  logic [48:0]          out_distance,
  input  logic                 out_too_close,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [THR_W-1:0]     cfg_zero_threshold,
  output int                   mismatch_count,
  output int                   outstanding
);

  localparam int          STAGES      = 62;
  localparam int          REPORT_CAP  = 200;
  localparam logic [63:0] RAD_TO_TURN = 64'd2935890503282001226;
  localparam logic [63:0] HALF_CIRCLE = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [31:0] bearing;
    logic [48:0] distance;
    logic        too_close;
  } polar_t;

  logic [63:0]      atan_turn [0:STAGES-1];
  logic [THR_W-1:0] threshold;
  polar_t           bearing_distance_q [$];
  int               err_total;
  int               shown;

  // atan(2^-i) as a fraction of 2^64 per turn
  initial begin : build_atan
    logic [63:0]  acc;
    logic [63:0]  term;
    logic [127:0] prod;
    atan_turn[0] = 64'h2000_0000_0000_0000;
    for (int i = 1; i < STAGES; i++) begin
      acc = '0;
      for (int k = 0; i * (2 * k + 1) <= 63; k++) begin
        term = (64'd1 << (64 - i * (2 * k + 1))) / 64'(2 * k + 1);
        if (k % 2 != 0) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      prod = {64'd0, acc} * {64'd0, RAD_TO_TURN};
      atan_turn[i] = prod[127:64];
    end
  end

  function automatic polar_t predict_bearing_distance(input logic signed [47:0] fe,
                                                      input logic signed [47:0] fn,
                                                      input logic signed [47:0] te,
                                                      input logic signed [47:0] tn,
                                                      input logic [THR_W-1:0]   thr);
    polar_t             res;
    logic signed [63:0] dy, dx, x, y, xs, ys;
    logic [127:0]       ay, ax, sum;
    logic [63:0]        m, z, root, cand;
    res = '0;
    dy  = {{16{te[47]}}, te} - {{16{fe[47]}}, fe};
    dx  = {{16{tn[47]}}, tn} - {{16{fn[47]}}, fn};
    ay  = {64'd0, (dy[63] ? (64'd0 - dy) : dy)};
    ax  = {64'd0, (dx[63] ? (64'd0 - dx) : dx)};
    sum = ay * ay + ax * ax;
    // exact squared distance against squared threshold
    if (sum < {108'd0, thr} * {108'd0, thr}) begin
      res.too_close = 1'b1;
      return res;
    end
    // integer root, then round half up
    root = '0;
    for (int b = 61; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= sum) begin
        root = cand;
      end
    end
    if (sum > {64'd0, root} * {64'd0, root} + {64'd0, root}) begin
      root = root + 64'd1;
    end
    res.distance = root[48:0];
    // vectoring rotation toward the positive north axis
    x = dx;
    y = dy;
    z = '0;
    m = ax[63:0] | ay[63:0];
    if (m != 0) begin
      while (m < (64'd1 << 60)) begin
        m = m << 1;
        x = x <<< 1;
        y = y <<< 1;
      end
      if (x[63]) begin
        x = 64'sd0 - x;
        y = 64'sd0 - y;
        z = HALF_CIRCLE;
      end
      for (int i = 0; i < STAGES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (!y[63]) begin
          x = x + ys;
          y = y - xs;
          z = z + atan_turn[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - atan_turn[i];
        end
      end
      z = z + (64'd1 << 31);
      res.bearing = z[63:32];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    polar_t seen;
    polar_t want;
    if (!rst_n) begin
      threshold <= THR_W'(1);
      bearing_distance_q.delete();
      err_total = 0;
      shown = 0;
      mismatch_count <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        threshold <= cfg_zero_threshold;
      end
      if (in_valid && !in_stall) begin
        bearing_distance_q.push_back(predict_bearing_distance(in_from_east, in_from_north,
                                                              in_to_east, in_to_north,
                                                              threshold));
      end
      if (out_valid && !out_stall) begin
        seen.bearing   = out_bearing_angle;
        seen.distance  = out_distance;
        seen.too_close = out_too_close;
        if (bearing_distance_q.size() == 0) begin
          err_total++;
          if (shown++ < REPORT_CAP) begin
            $display("%0t: result beat with none expected: bearing %0d distance %0d flag %0b",
                     $time, seen.bearing, seen.distance, seen.too_close);
          end
        end else begin
          want = bearing_distance_q.pop_front();
          if (seen.bearing !== want.bearing) begin
            err_total++;
            if (shown++ < REPORT_CAP) begin
              $display("%0t: bearing_angle expected %0d actual %0d",
                       $time, want.bearing, seen.bearing);
            end
          end
          if (seen.distance !== want.distance) begin
            err_total++;
            if (shown++ < REPORT_CAP) begin
              $display("%0t: distance expected %0d actual %0d",
                       $time, want.distance, seen.distance);
            end
          end
          if (seen.too_close !== want.too_close) begin
            err_total++;
            if (shown++ < REPORT_CAP) begin
              $display("%0t: too_close expected %0b actual %0b",
                       $time, want.too_close, seen.too_close);
            end
          end
        end
      end
      mismatch_count <= err_total;
      outstanding <= bearing_distance_q.size();
    end
  end

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// drives point pairs and zero threshold settings into bearing_distance_polar
// with random idle and stall cycles; the checker predicts every result beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import bdp_pkg::*;

  localparam int                 QUIET_LIMIT = 2000;   // cycles with no beat at all
  localparam int                 SETTLE      = 80;     // pipeline is 68 deep
  localparam int                 PHASE_BEATS = 300;
  localparam logic signed [47:0] C_MIN       = 48'sh8000_0000_0000;
  localparam logic signed [47:0] C_MAX       = 48'sh7FFF_FFFF_FFFF;
  localparam logic [THR_W-1:0]   THR_MAX     = '1;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic signed [47:0]     in_from_east = '0;
  logic signed [47:0]     in_from_north = '0;
  logic signed [47:0]     in_to_east = '0;
  logic signed [47:0]     in_to_north = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [31:0]            out_bearing_angle;
  logic [48:0]            out_distance;
  logic                   out_too_close;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [THR_W-1:0]       cfg_zero_threshold = '0;

  int                     mismatch_count;
  int                     outstanding;
  int                     in_gap_max = 10;
  int                     out_gap_max = 10;
  int                     stall_left = 0;
  int                     cur_thr = 1;

  always #2 clk = ~clk;

  bearing_distance_polar u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_from_east       (in_from_east),
    .in_from_north      (in_from_north),
    .in_to_east         (in_to_east),
    .in_to_north        (in_to_north),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_bearing_angle  (out_bearing_angle),
    .out_distance       (out_distance),
    .out_too_close      (out_too_close),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_zero_threshold (cfg_zero_threshold)
  );

  bearing_distance_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_from_east       (in_from_east),
    .in_from_north      (in_from_north),
    .in_to_east         (in_to_east),
    .in_to_north        (in_to_north),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_bearing_angle  (out_bearing_angle),
    .out_distance       (out_distance),
    .out_too_close      (out_too_close),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_zero_threshold (cfg_zero_threshold),
    .mismatch_count     (mismatch_count),
    .outstanding        (outstanding)
  );

  // result side: after each accepted beat hold stall for a drawn number of cycles
  always @(posedge clk) begin
    int gap;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left != 1);
    end else if (out_valid && !out_stall) begin
      gap = $urandom_range(0, out_gap_max);
      stall_left <= gap;
      out_stall <= (gap != 0);
    end
  end

  function automatic logic signed [47:0] rand_coord();
    return 48'({$urandom, $urandom});
  endfunction

  // a coordinate from the corners of the range or anywhere
  function automatic logic signed [47:0] edge_coord();
    case ($urandom_range(0, 5))
      0: return C_MIN;
      1: return C_MAX;
      2: return '0;
      3: return -48'sd1;
      4: return 48'sd1;
      default: return rand_coord();
    endcase
  endfunction

  // one offset out of {0, +k, -k}
  function automatic logic signed [47:0] axis_pick(input logic signed [47:0] k);
    case ($urandom_range(0, 2))
      0: return '0;
      1: return k;
      default: return -k;
    endcase
  endfunction

  // one point pair beat, preceded by a drawn number of idle cycles
  task automatic send_pair(input logic signed [47:0] fe, input logic signed [47:0] fn,
                           input logic signed [47:0] te, input logic signed [47:0] tn);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_from_east  <= fe;
    in_from_north <= fn;
    in_to_east    <= te;
    in_to_north   <= tn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop sending and wait until every predicted result beat has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // only called with the pipeline empty
  task automatic write_threshold(input logic [THR_W-1:0] thr);
    cfg_valid          <= 1'b1;
    cfg_zero_threshold <= thr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_thr = int'(thr);
  endtask

  // random point pair, mostly well-formed offsets from a random origin
  task automatic random_pair();
    logic signed [47:0] fe, fn, de, dn;
    int                 span;
    fe   = rand_coord();
    fn   = rand_coord();
    span = cur_thr + 2;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        // anywhere in the plane, differences up to full scale
        send_pair(fe, fn, rand_coord(), rand_coord());
      end
      3, 4, 5: begin
        // offsets of every magnitude
        de = rand_coord() >>> $urandom_range(0, 47);
        dn = rand_coord() >>> $urandom_range(0, 47);
        send_pair(fe, fn, fe + de, fn + dn);
      end
      6, 7: begin
        // around the zero threshold circle
        de = 48'(int'($urandom_range(0, 2 * span)) - span);
        dn = 48'(int'($urandom_range(0, 2 * span)) - span);
        send_pair(fe, fn, fe + de, fn + dn);
      end
      8: begin
        // on the axes and diagonals
        de = rand_coord() >>> $urandom_range(0, 47);
        send_pair(fe, fn, fe + axis_pick(de), fn + axis_pick(de));
      end
      default: begin
        send_pair(edge_coord(), edge_coord(), edge_coord(), edge_coord());
      end
    endcase
  endtask

  initial begin : stimulus
    logic [THR_W-1:0] phase_thr [5];
    int               phase_in_gap [5];
    int               phase_out_gap [5];
    phase_thr     = '{THR_W'(1), '0, THR_MAX, THR_W'($urandom), THR_W'($urandom_range(2, 64))};
    // gap limits per phase: mixed, back to back, and each side alone
    phase_in_gap  = '{10, 0, 10, 0, 10};
    phase_out_gap = '{10, 0, 0, 10, 10};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // threshold still at its reset value of one
    send_pair(0, 0, 0, 0);                  // zero vector is too close
    send_pair(0, 0, 0, 1);                  // due north
    send_pair(0, 0, 1, 0);                  // due east
    send_pair(0, 0, 0, -1);                 // due south
    send_pair(0, 0, -1, 0);                 // due west
    send_pair(0, 0, 1, 1);                  // root 1.41 rounds down
    send_pair(0, 0, 2, 3);                  // root 3.61 rounds up
    send_pair(C_MIN, C_MIN, C_MAX, C_MAX);  // largest distance, northeast
    send_pair(C_MAX, C_MAX, C_MIN, C_MIN);  // largest distance, southwest
    send_pair(C_MIN, 0, C_MAX, 0);          // widest east offset
    send_pair(0, C_MIN, -1, C_MAX);         // just west of north, rounds to a full turn
    send_pair(0, C_MAX, 1, C_MIN);          // just east of south
    drain_results();

    // zero threshold: the zero vector is no longer too close
    write_threshold('0);
    send_pair(48'sd5, 48'sd5, 48'sd5, 48'sd5);
    send_pair(0, 0, 0, 1);
    drain_results();

    // largest threshold, exact compare on both sides of the circle
    write_threshold(THR_MAX);
    send_pair(0, 0, 0, 1048575);            // exactly on the circle
    send_pair(0, 0, 1, 1048574);            // just inside
    send_pair(0, 0, 1024, 1048574);         // inside though it rounds to the threshold
    send_pair(0, 0, -1048575, 0);           // on the circle, due west
    send_pair(C_MAX, C_MAX, C_MAX - 5, C_MAX - 7);
    drain_results();

    for (int p = 0; p < 5; p++) begin
      write_threshold(phase_thr[p]);
      in_gap_max = phase_in_gap[p];
      out_gap_max <= phase_out_gap[p];
      repeat (PHASE_BEATS) begin
        // now and then let the pipeline run dry mid phase
        if ($urandom_range(0, 199) == 0) begin
          drain_results();
        end
        random_pair();
      end
      drain_results();
    end

    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ends the run if no beat moves on any channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

endmodule
